### hdl/swt_pkg.sv
// Shared types, character codes and helper functions for the shell word tokenizer.
// No dependencies; the lexer, the result buffer and the top level import this package.
package swt_pkg;

   // Character codes
   localparam logic [7:0] CH_BEL   = 8'h07;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_HT    = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_BSL   = 8'h5C;

   // Lexer modes; codes six and seven are never entered
   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_BARE    = 3'd1,
      MODE_ESC_BARE = 3'd2,
      MODE_DQ      = 3'd3,
      MODE_ESC_DQ  = 3'd4,
      MODE_SQ      = 3'd5
   } mode_type;

   // One result word
   typedef struct packed {
      logic       has_char;
      logic [7:0] out_char;
      logic       word_end;
      logic       line_done;
      logic       run_last;
   } rec_type;

   // Results caused by one input byte
   typedef struct packed {
      logic [1:0] count;
      rec_type    rec0;
      rec_type    rec1;
   } step_type;

   // Lexer status seen by the top level
   typedef struct packed {
      mode_type mode;
      logic     word_open;
   } lex_stat_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_HT) && (c <= CH_CR));
   endfunction

   // Control code for an escape letter, zero when the letter has none
   function automatic logic [7:0] ctrl_code(input logic [7:0] c);
      logic [7:0] code;
      case (c)
         8'h61: code = CH_BEL; // a
         8'h62: code = CH_BS;  // b
         8'h65: code = CH_ESC; // e
         8'h66: code = CH_FF;  // f
         8'h6E: code = CH_LF;  // n
         8'h72: code = CH_CR;  // r
         8'h74: code = CH_HT;  // t
         8'h76: code = CH_VT;  // v
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

### hdl/swt_req_if.sv
// Input channel of the shell word tokenizer: one command line byte per word.
// Depends on nothing.
interface swt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       line_end;

   modport source (output valid, output in_byte, output line_end, input ready);
   modport sink   (input valid, input in_byte, input line_end, output ready);
endinterface

### hdl/swt_rsp_if.sv
// Result channel of the shell word tokenizer: one word character or word end per word.
// Depends on nothing.
interface swt_rsp_if;
   logic       valid;
   logic       ready;
   logic       has_char;
   logic [7:0] out_char;
   logic       word_end;
   logic       line_done;
   logic       run_last;

   modport source (output valid, output has_char, output out_char, output word_end,
                   output line_done, output run_last, input ready);
   modport sink   (input valid, input has_char, input out_char, input word_end,
                   input line_done, input run_last, output ready);
endinterface

### hdl/swt_lexer.sv
// Lexer state machine: holds the quoting mode and open-word flag, and decodes one
// byte into up to two result words. Depends on swt_pkg.
module swt_lexer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            in_byte,
   input  logic                  line_end,
   output swt_pkg::step_type     step,
   output swt_pkg::lex_stat_type stat
);
   import swt_pkg::*;

   mode_type   mode_ff, mode_in;
   logic       open_ff, open_in;
   logic [7:0] ctl;
   logic       esc_lit;
   logic [1:0] n;
   rec_type    r0, r1;

   // Escape decode shared by both escape modes
   assign ctl     = ctrl_code(in_byte);
   assign esc_lit = (in_byte == CH_DQ) || (in_byte == CH_BSL) ||
                    ((mode_ff == MODE_ESC_BARE) &&
                     ((in_byte == CH_SPACE) || (in_byte == CH_SQ)));

   // Next mode
   always_comb begin
      mode_in = MODE_IDLE;
      unique case (mode_ff)
         MODE_BARE: begin
            if (in_byte == CH_BSL) mode_in = MODE_ESC_BARE;
            else if (is_blank(in_byte)) mode_in = MODE_IDLE;
            else mode_in = MODE_BARE;
         end
         MODE_ESC_BARE: mode_in = MODE_BARE;
         MODE_DQ: begin
            if (in_byte == CH_BSL) mode_in = MODE_ESC_DQ;
            else if (in_byte == CH_DQ) mode_in = MODE_IDLE;
            else mode_in = MODE_DQ;
         end
         MODE_ESC_DQ: mode_in = MODE_DQ;
         MODE_SQ: begin
            if (in_byte == CH_SQ) mode_in = MODE_IDLE;
            else mode_in = MODE_SQ;
         end
         default: begin
            if (in_byte == CH_DQ) mode_in = MODE_DQ;
            else if (in_byte == CH_SQ) mode_in = MODE_SQ;
            else if (!is_blank(in_byte)) mode_in = MODE_BARE;
            else mode_in = MODE_IDLE;
         end
      endcase
      // drop back between words after the final byte
      if (line_end) mode_in = MODE_IDLE;
   end

   // Result words and open-word flag
   always_comb begin
      n       = 2'd0;
      r0      = '0;
      r1      = '0;
      open_in = open_ff;
      unique case (mode_ff)
         MODE_BARE: begin
            if (in_byte == CH_BSL) begin
               n = 2'd0;
            end else if (is_blank(in_byte)) begin
               r0.word_end = 1'b1;
               n           = 2'd1;
               open_in     = 1'b0;
            end else begin
               r0.has_char = 1'b1;
               r0.out_char = in_byte;
               n           = 2'd1;
               open_in     = 1'b1;
            end
         end
         MODE_ESC_BARE, MODE_ESC_DQ: begin
            r0.has_char = 1'b1;
            open_in     = 1'b1;
            if (esc_lit) begin
               r0.out_char = in_byte;
               n           = 2'd1;
            end else if (ctl != 8'h00) begin
               r0.out_char = ctl;
               n           = 2'd1;
            end else begin
               // unknown escape keeps its backslash
               r0.out_char = CH_BSL;
               r1.has_char = 1'b1;
               r1.out_char = in_byte;
               n           = 2'd2;
            end
         end
         MODE_DQ: begin
            if (in_byte == CH_BSL) begin
               n = 2'd0;
            end else if (in_byte == CH_DQ) begin
               r0.word_end = 1'b1;
               n           = 2'd1;
               open_in     = 1'b0;
            end else begin
               r0.has_char = 1'b1;
               r0.out_char = in_byte;
               n           = 2'd1;
               open_in     = 1'b1;
            end
         end
         MODE_SQ: begin
            if (in_byte == CH_SQ) begin
               r0.word_end = 1'b1;
               n           = 2'd1;
               open_in     = 1'b0;
            end else begin
               r0.has_char = 1'b1;
               r0.out_char = in_byte;
               n           = 2'd1;
               open_in     = 1'b1;
            end
         end
         default: begin
            if (!is_blank(in_byte) && (in_byte != CH_DQ) && (in_byte != CH_SQ)) begin
               r0.has_char = 1'b1;
               r0.out_char = in_byte;
               n           = 2'd1;
               open_in     = 1'b1;
            end
         end
      endcase

      // close an open word on the final byte, and always emit at least one word there
      if (line_end) begin
         if (open_in) begin
            if ((n == 2'd1) && !r0.word_end) begin
               r0.word_end = 1'b1;
            end else if ((n == 2'd2) && !r1.word_end) begin
               r1.word_end = 1'b1;
            end else if (n == 2'd0) begin
               r0.word_end = 1'b1;
               n           = 2'd1;
            end else if (n == 2'd1) begin
               r1.word_end = 1'b1;
               n           = 2'd2;
            end
         end
         if (n == 2'd0) n = 2'd1;
         open_in = 1'b0;
      end

      // mark the last word of this byte
      if (n == 2'd2) begin
         r1.run_last  = 1'b1;
         r1.line_done = line_end;
      end else begin
         r0.run_last  = 1'b1;
         r0.line_done = line_end;
      end
   end

   // Advance state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         open_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         open_ff <= open_in;
      end
   end

   assign step.count = n;
   assign step.rec0  = r0;
   assign step.rec1  = r1;
   assign stat.mode      = mode_ff;
   assign stat.word_open = open_ff;

endmodule

### hdl/swt_obuf.sv
// Two-entry result buffer: loads the words of one byte and drains them one per cycle while the receiver is ready.
// Depends on swt_pkg and swt_rsp_if.
module swt_obuf (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  swt_pkg::step_type step,
   output logic              space,
   swt_rsp_if.source         rsp
);
   import swt_pkg::*;

   logic [1:0] cnt_ff, cnt_in;
   rec_type    rec0_ff, rec0_in;
   rec_type    rec1_ff, rec1_in;
   logic       take;

   assign take  = rsp.valid && rsp.ready;
   // accept a new byte when the buffer is empty or empties this cycle
   assign space = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp.ready);

   // Load, shift or hold
   always_comb begin
      cnt_in  = cnt_ff;
      rec0_in = rec0_ff;
      rec1_in = rec1_ff;
      if (load) begin
         cnt_in  = step.count;
         rec0_in = step.rec0;
         rec1_in = step.rec1;
      end else if (take) begin
         if (cnt_ff == 2'd2) begin
            cnt_in  = 2'd1;
            rec0_in = rec1_ff;
         end else begin
            cnt_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= 2'd0;
      else cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      rec0_ff <= rec0_in;
      rec1_ff <= rec1_in;
   end

   assign rsp.valid     = (cnt_ff != 2'd0);
   assign rsp.has_char  = rec0_ff.has_char;
   assign rsp.out_char  = rec0_ff.out_char;
   assign rsp.word_end  = rec0_ff.word_end;
   assign rsp.line_done = rec0_ff.line_done;
   assign rsp.run_last  = rec0_ff.run_last;

endmodule

### hdl/shell_word_tokenizer_unit.sv
// Shell word tokenizer top level. The first result word appears in the cycle after the byte is taken.
// Throughput: one byte per cycle while results are taken and each byte gives at most one word; a byte
// that gives two words holds off the next, as the two-entry buffer drains one word per cycle when ready.
// Reset (synchronous, active high) returns the lexer between words and empties the buffer.
// Depends on swt_pkg, swt_req_if, swt_rsp_if, swt_lexer and swt_obuf.
module shell_word_tokenizer_unit (
   input logic       clock,
   input logic       reset,
   swt_req_if.sink   req,
   swt_rsp_if.source rsp
);
   import swt_pkg::*;

   step_type     step;
   lex_stat_type stat;
   logic         space;
   logic         accept;

   assign req.ready = space;
   assign accept    = req.valid && req.ready;

   // Decode the byte and keep the quoting state
   swt_lexer u_lexer (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_byte  (req.in_byte),
      .line_end (req.line_end),
      .step     (step),
      .stat     (stat)
   );

   // Hold and drain the result words
   swt_obuf u_obuf (
      .clock (clock),
      .reset (reset),
      .load  (accept),
      .step  (step),
      .space (space),
      .rsp   (rsp)
   );

   // A final byte leaves the lexer between words with no open word
   a_line_reset: assert property (@(posedge clock) disable iff (reset)
      accept && req.line_end |=> (stat.mode == MODE_IDLE) && !stat.word_open)
      else $error("lexer not idle after final byte");

   // The first of two words blocks the next byte
   a_pair_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.run_last |-> !req.ready)
      else $error("byte taken while a word pair is pending");

   // An empty result word only marks the end of the line
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.has_char && !rsp.word_end |-> rsp.line_done && rsp.run_last)
      else $error("empty result word outside line end");

   // A done line ends its byte's run
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.line_done |-> rsp.run_last)
      else $error("line done before last word of the byte");

endmodule
